[hw/rtl/sha1_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-1 package
// Shared widths, initial vector, round constants and round functions.
// ----------------------------------------------------------------------------
package sha1_pkg;

    localparam int BYTE_W  = 8;
    localparam int WORD_W  = 32;
    localparam int WNUM_W  = 3;
    localparam int COUNT_W = 61;
    localparam int LEN_W   = 64;
    localparam int POS_W   = 6;
    localparam int ROUND_W = 7;

    typedef logic [WORD_W-1:0] t_word;
    typedef logic [BYTE_W-1:0] t_byte;

    localparam int    NUM_ROUNDS   = 80;
    localparam int    DIGEST_WORDS = 5;
    localparam t_byte PAD_BYTE     = 8'h80;

    localparam t_word IV0 = 32'h67452301;
    localparam t_word IV1 = 32'hefcdab89;
    localparam t_word IV2 = 32'h98badcfe;
    localparam t_word IV3 = 32'h10325476;
    localparam t_word IV4 = 32'hc3d2e1f0;

    localparam t_word K0 = 32'h5a827999;
    localparam t_word K1 = 32'h6ed9eba1;
    localparam t_word K2 = 32'h8f1bbcdc;
    localparam t_word K3 = 32'hca62c1d6;

    function automatic t_word iv_word(input logic [WNUM_W-1:0] idx);
        t_word w;
        case (idx)
            3'd0:    w = IV0;
            3'd1:    w = IV1;
            3'd2:    w = IV2;
            3'd3:    w = IV3;
            default: w = IV4;
        endcase
        return w;
    endfunction

    // f(b,c,d) + K for round t
    function automatic t_word round_fk(input logic [ROUND_W-1:0] rnd,
                                       input t_word b, input t_word c,
                                       input t_word d);
        t_word f;
        t_word k;
        if (rnd < ROUND_W'(20)) begin
            f = (b & c) | (~b & d);
            k = K0;
        end else if (rnd < ROUND_W'(40)) begin
            f = b ^ c ^ d;
            k = K1;
        end else if (rnd < ROUND_W'(60)) begin
            f = (b & c) | (b & d) | (c & d);
            k = K2;
        end else begin
            f = b ^ c ^ d;
            k = K3;
        end
        return f + k;
    endfunction

endpackage

[hw/rtl/sha1_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-1 stream interfaces
// Byte input channel and digest word output channel, valid/ready.
// ----------------------------------------------------------------------------
interface sha1_in_if;
    logic                        valid;
    logic                        ready;
    logic [sha1_pkg::BYTE_W-1:0] data_byte;
    logic                        byte_present;
    logic                        end_of_message;

    modport source (output valid, data_byte, byte_present, end_of_message,
                    input ready);
    modport sink   (input valid, data_byte, byte_present, end_of_message,
                    output ready);
endinterface

interface sha1_out_if;
    logic                        valid;
    logic                        ready;
    logic [sha1_pkg::WORD_W-1:0] digest_word;
    logic [sha1_pkg::WNUM_W-1:0] word_number;
    logic                        final_word;

    modport source (output valid, digest_word, word_number, final_word,
                    input ready);
    modport sink   (input valid, digest_word, word_number, final_word,
                    output ready);
endinterface

[hw/rtl/sha1_message_digest.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-1 message digest
// Byte-serial SHA-1 with one shared round unit and a 16-word schedule shift.
// ----------------------------------------------------------------------------
// Message bytes are shifted in as they are accepted; every 64th byte starts a
// compression (80 rounds on the single round adder, then a chain fold).
// End of message: pad/length bytes (up to 72) with an idle step ahead of the
// length, one or two compressions, then five digest words at one per cycle while ready is high.
// Input not ready from a block's last byte until its compression is done.
// Reset (synchronous): chain value to the initial vector, count cleared.
// ----------------------------------------------------------------------------
module sha1_message_digest (
    input  logic       i_clk,
    input  logic       i_rst_n,
    sha1_in_if.sink    i_in,
    sha1_out_if.source o_out
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD80,
        ST_PADZ,
        ST_LEN,
        ST_ROUND,
        ST_FOLD,
        ST_OUT
    } t_state;

    t_state r_state, n_state;
    t_state r_ret, n_ret;

    sha1_pkg::t_word                    r_blk [16];
    sha1_pkg::t_word                    r_h   [sha1_pkg::DIGEST_WORDS];
    sha1_pkg::t_word                    r_wv  [sha1_pkg::DIGEST_WORDS];
    logic [sha1_pkg::COUNT_W-1:0]       r_cnt;
    logic [sha1_pkg::POS_W-1:0]         r_pos;
    logic [sha1_pkg::ROUND_W-1:0]       r_rnd;
    logic [sha1_pkg::WNUM_W-1:0]        r_widx;

    logic                               in_acc;
    logic                               out_acc;
    logic                               shift_en;
    sha1_pkg::t_byte                    shift_byte;
    logic [sha1_pkg::LEN_W-1:0]         len_bits;
    sha1_pkg::t_word                    t_sum;
    sha1_pkg::t_word                    sched_new;

    assign in_acc   = i_in.valid && i_in.ready;
    assign out_acc  = o_out.valid && o_out.ready;
    assign len_bits = {r_cnt, 3'b000};

    assign i_in.ready        = (r_state == ST_IDLE);
    assign o_out.valid       = (r_state == ST_OUT);
    assign o_out.digest_word = r_h[0];
    assign o_out.word_number = r_widx;
    assign o_out.final_word  = (r_widx == sha1_pkg::WNUM_W'(sha1_pkg::DIGEST_WORDS - 1));

    // shared round unit
    assign t_sum = {r_wv[0][26:0], r_wv[0][31:27]} + r_wv[4] + r_blk[0]
                 + sha1_pkg::round_fk(r_rnd, r_wv[1], r_wv[2], r_wv[3]);

    always_comb begin
        sched_new = r_blk[13] ^ r_blk[8] ^ r_blk[2] ^ r_blk[0];
        sched_new = {sched_new[30:0], sched_new[31]};
    end

    always_comb begin
        n_state    = r_state;
        n_ret      = r_ret;
        shift_en   = 1'b0;
        shift_byte = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    if (i_in.byte_present) begin
                        shift_en   = 1'b1;
                        shift_byte = i_in.data_byte;
                    end
                    if (i_in.byte_present && (r_pos == '1)) begin
                        n_state = ST_ROUND;
                        n_ret   = i_in.end_of_message ? ST_PAD80 : ST_IDLE;
                    end else if (i_in.end_of_message) begin
                        n_state = ST_PAD80;
                    end
                end
            end
            ST_PAD80: begin
                shift_en   = 1'b1;
                shift_byte = sha1_pkg::PAD_BYTE;
                if (r_pos == '1) begin
                    n_state = ST_ROUND;
                    n_ret   = ST_PADZ;
                end else begin
                    n_state = ST_PADZ;
                end
            end
            ST_PADZ: begin
                if (r_pos == sha1_pkg::POS_W'(56)) begin
                    n_state = ST_LEN;
                end else begin
                    shift_en = 1'b1;
                    if (r_pos == '1) begin
                        n_state = ST_ROUND;
                        n_ret   = ST_PADZ;
                    end
                end
            end
            ST_LEN: begin
                shift_en   = 1'b1;
                shift_byte = len_bits[{~r_pos[2:0], 3'b000} +: sha1_pkg::BYTE_W];
                if (r_pos == '1) begin
                    n_state = ST_ROUND;
                    n_ret   = ST_OUT;
                end
            end
            ST_ROUND: begin
                if (r_rnd == sha1_pkg::ROUND_W'(sha1_pkg::NUM_ROUNDS - 1)) begin
                    n_state = ST_FOLD;
                end
            end
            ST_FOLD: begin
                n_state = r_ret;
            end
            ST_OUT: begin
                if (out_acc && o_out.final_word) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        // schedule / block shift register
        if (shift_en) begin
            for (int i = 0; i < 15; i++) begin
                r_blk[i] <= {r_blk[i][23:0], r_blk[i+1][31:24]};
            end
            r_blk[15] <= {r_blk[15][23:0], shift_byte};
        end else if (r_state == ST_ROUND) begin
            for (int i = 0; i < 15; i++) begin
                r_blk[i] <= r_blk[i+1];
            end
            r_blk[15] <= sched_new;
        end

        // working variables: preload from chain outside compression
        if (r_state == ST_ROUND) begin
            r_wv[0] <= t_sum;
            r_wv[1] <= r_wv[0];
            r_wv[2] <= {r_wv[1][1:0], r_wv[1][31:2]};
            r_wv[3] <= r_wv[2];
            r_wv[4] <= r_wv[3];
        end else begin
            for (int i = 0; i < sha1_pkg::DIGEST_WORDS; i++) begin
                r_wv[i] <= r_h[i];
            end
        end

        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_ret   <= ST_IDLE;
            r_cnt   <= '0;
            r_pos   <= '0;
            r_rnd   <= '0;
            r_widx  <= '0;
            for (int i = 0; i < sha1_pkg::DIGEST_WORDS; i++) begin
                r_h[i] <= sha1_pkg::iv_word(sha1_pkg::WNUM_W'(i));
            end
        end else begin
            r_state <= n_state;
            r_ret   <= n_ret;
            if (shift_en) begin
                r_pos <= r_pos + 1'b1;
            end
            if (in_acc && i_in.byte_present) begin
                r_cnt <= r_cnt + 1'b1;
            end else if ((r_state == ST_LEN) && (r_pos == '1)) begin
                r_cnt <= '0;
            end
            r_rnd <= (r_state == ST_ROUND) ? r_rnd + 1'b1 : '0;
            if (r_state == ST_FOLD) begin
                for (int i = 0; i < sha1_pkg::DIGEST_WORDS; i++) begin
                    r_h[i] <= r_h[i] + r_wv[i];
                end
            end else if (out_acc) begin
                // shift digest out, initial vector in behind it
                for (int i = 0; i < sha1_pkg::DIGEST_WORDS - 1; i++) begin
                    r_h[i] <= r_h[i+1];
                end
                r_h[sha1_pkg::DIGEST_WORDS-1] <= sha1_pkg::iv_word(r_widx);
                r_widx <= o_out.final_word ? '0 : r_widx + 1'b1;
            end
        end
    end

    a_out_blocks_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> !i_in.ready)
        else $error("input ready while digest pending");

    a_round_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_ROUND) |-> (r_rnd < sha1_pkg::ROUND_W'(sha1_pkg::NUM_ROUNDS)))
        else $error("round counter out of range");

    a_len_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_LEN) |-> (r_pos[5:3] == 3'b111))
        else $error("length bytes outside last eight block bytes");

    a_iv_restored: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_acc && o_out.final_word) |=>
            ((r_h[0] == sha1_pkg::IV0) && (r_h[4] == sha1_pkg::IV4)
             && (r_cnt == '0) && (r_pos == '0) && i_in.ready))
        else $error("chain not back to initial vector after digest");

    a_fold_from_round: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_FOLD) |-> ($past(r_state) == ST_ROUND))
        else $error("fold without compression");

endmodule

[sim/sha1_digest_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-1 digest checker
// Watches the byte and digest channels. Every accepted byte word feeds a
// local SHA-1 model. An end mark queues the five digest words it produces.
// Each accepted digest word is compared with the oldest queued word.
// ----------------------------------------------------------------------------
module sha1_digest_checker (
    input  logic i_clk,
    input  logic i_rst_n,
    sha1_in_if   i_in,
    sha1_out_if  i_out,
    output int   o_fail_count,
    output int   o_pending
);

    typedef struct packed {
        sha1_pkg::t_word             digest_word;
        logic [sha1_pkg::WNUM_W-1:0] word_number;
        logic                        final_word;
    } t_digest_exp;

    localparam sha1_pkg::t_word INIT_HASH [sha1_pkg::DIGEST_WORDS] =
        '{sha1_pkg::IV0, sha1_pkg::IV1, sha1_pkg::IV2, sha1_pkg::IV3, sha1_pkg::IV4};

    sha1_pkg::t_word              hash_state [sha1_pkg::DIGEST_WORDS];
    sha1_pkg::t_word              block_buf  [16];
    logic [sha1_pkg::COUNT_W-1:0] msg_len_bytes;
    t_digest_exp                  digest_expect_q [$];
    t_digest_exp                  want;
    t_digest_exp                  got;
    int                           fails;

    function automatic sha1_pkg::t_word rot_left(input sha1_pkg::t_word x, input int n);
        return (x << n) | (x >> (sha1_pkg::WORD_W - n));
    endfunction

    function automatic void pack_byte(input int pos, input sha1_pkg::t_byte val);
        int w;
        int sh;
        w  = (pos >> 2) & 15;
        sh = 24 - 8 * (pos & 3);
        if ((pos & 3) == 0)
            block_buf[w] = {val, 24'h0};
        else
            block_buf[w] = block_buf[w] | (sha1_pkg::t_word'(val) << sh);
    endfunction

    function automatic void sha1_compress();
        sha1_pkg::t_word sched [sha1_pkg::NUM_ROUNDS];
        sha1_pkg::t_word a, b, c, d, e, f, k, t;
        for (int i = 0; i < 16; i++)
            sched[i] = block_buf[i];
        for (int i = 16; i < sha1_pkg::NUM_ROUNDS; i++)
            sched[i] = rot_left(sched[i-3] ^ sched[i-8] ^ sched[i-14] ^ sched[i-16], 1);
        a = hash_state[0];
        b = hash_state[1];
        c = hash_state[2];
        d = hash_state[3];
        e = hash_state[4];
        for (int r = 0; r < sha1_pkg::NUM_ROUNDS; r++) begin
            if (r < 20) begin
                f = (b & c) | (~b & d);
                k = sha1_pkg::K0;
            end else if (r < 40) begin
                f = b ^ c ^ d;
                k = sha1_pkg::K1;
            end else if (r < 60) begin
                f = (b & c) | (b & d) | (c & d);
                k = sha1_pkg::K2;
            end else begin
                f = b ^ c ^ d;
                k = sha1_pkg::K3;
            end
            t = rot_left(a, 5) + f + e + k + sched[r];
            e = d;
            d = c;
            c = rot_left(b, 30);
            b = a;
            a = t;
        end
        hash_state[0] = hash_state[0] + a;
        hash_state[1] = hash_state[1] + b;
        hash_state[2] = hash_state[2] + c;
        hash_state[3] = hash_state[3] + d;
        hash_state[4] = hash_state[4] + e;
    endfunction

    function automatic void restart_digest();
        for (int i = 0; i < sha1_pkg::DIGEST_WORDS; i++)
            hash_state[i] = INIT_HASH[i];
        msg_len_bytes = '0;
    endfunction

    function automatic void feed_digest_item(input sha1_pkg::t_byte data,
                                             input logic present, input logic eom);
        int          pos;
        logic [63:0] bit_len;
        t_digest_exp item;
        if (present) begin
            pos = int'(msg_len_bytes[sha1_pkg::POS_W-1:0]);
            pack_byte(pos, data);
            msg_len_bytes = msg_len_bytes + 1'b1;
            if (pos == 63)
                sha1_compress();
        end
        if (eom) begin
            pos = int'(msg_len_bytes[sha1_pkg::POS_W-1:0]);
            pack_byte(pos, sha1_pkg::PAD_BYTE);
            pos++;
            if (pos > 56) begin
                for (; pos < 64; pos++)
                    pack_byte(pos, 8'h00);
                sha1_compress();
                pos = 0;
            end
            for (; pos < 56; pos++)
                pack_byte(pos, 8'h00);
            bit_len = {msg_len_bytes, 3'b000};
            block_buf[14] = bit_len[63:32];
            block_buf[15] = bit_len[31:0];
            sha1_compress();
            for (int i = 0; i < sha1_pkg::DIGEST_WORDS; i++) begin
                item.digest_word = hash_state[i];
                item.word_number = sha1_pkg::WNUM_W'(i);
                item.final_word  = (i == sha1_pkg::DIGEST_WORDS - 1);
                digest_expect_q  = {digest_expect_q, item};
            end
            restart_digest();
        end
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            restart_digest();
            digest_expect_q.delete();
        end else begin
            if (i_out.valid && i_out.ready) begin
                got.digest_word = i_out.digest_word;
                got.word_number = i_out.word_number;
                got.final_word  = i_out.final_word;
                if (digest_expect_q.size() == 0) begin
                    $display("%0t: unexpected digest word: expected none, actual %h/%0d/%b",
                             $time, got.digest_word, got.word_number, got.final_word);
                    fails++;
                end else begin
                    want = digest_expect_q.pop_front();
                    if (got.digest_word !== want.digest_word ||
                        got.word_number !== want.word_number ||
                        got.final_word !== want.final_word) begin
                        $display("%0t: digest mismatch: expected %h/%0d/%b actual %h/%0d/%b",
                                 $time, want.digest_word, want.word_number,
                                 want.final_word, got.digest_word, got.word_number,
                                 got.final_word);
                        fails++;
                    end
                end
            end
            if (i_in.valid && i_in.ready)
                feed_digest_item(i_in.data_byte, i_in.byte_present, i_in.end_of_message);
        end
        o_fail_count <= fails;
        o_pending    <= digest_expect_q.size();
    end

endmodule

[sim/sha1_message_digest_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-1 message digest testbench
// Streams directed and random messages into the engine in bursts, with a
// receiver that stalls on its own pattern; the checker predicts and compares
// every digest word.
// ----------------------------------------------------------------------------
module sha1_message_digest_tb;

    localparam int CYCLE_LIMIT = 500000;
    localparam int LONG_HOLD   = 600;
    localparam int DRAIN_WAIT  = 200;

    logic i_clk;
    logic i_rst_n;
    int   fail_count;
    int   pending;
    int   cycle_cnt;
    int   items_sent;
    int   burst_left;

    sha1_in_if  in_bus ();
    sha1_out_if out_bus ();

    sha1_message_digest DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_bus),
        .o_out   (out_bus)
    );

    sha1_digest_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (in_bus),
        .i_out        (out_bus),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial i_clk = 1'b0;
    always #4 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // one byte word; gaps fall between bursts
    task automatic offer_word(input sha1_pkg::t_byte data, input logic present,
                              input logic eom);
        if (burst_left == 0) begin
            @(negedge i_clk);
            in_bus.valid <= 1'b0;
            repeat ($urandom_range(0, 9)) @(negedge i_clk);
            if ($urandom_range(0, 5) == 0)
                burst_left = $urandom_range(40, 100);
            else
                burst_left = $urandom_range(1, 16);
        end
        burst_left--;
        @(negedge i_clk);
        in_bus.valid          <= 1'b1;
        in_bus.data_byte      <= data;
        in_bus.byte_present   <= present;
        in_bus.end_of_message <= eom;
        @(posedge i_clk);
        while (!in_bus.ready) @(posedge i_clk);
        if (present || eom)
            items_sent++;
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        in_bus.valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
    endtask

    task automatic send_message(input int len, input bit end_on_byte);
        for (int i = 0; i < len; i++) begin
            if ($urandom_range(0, 9) == 0)
                offer_word(sha1_pkg::t_byte'($urandom), 1'b0, 1'b0);
            offer_word(sha1_pkg::t_byte'($urandom), 1'b1, end_on_byte && (i == len - 1));
        end
        if (!(end_on_byte && len > 0))
            offer_word(sha1_pkg::t_byte'($urandom), 1'b0, 1'b1);
    endtask

    // receiver: stretches of steady, random, sparse or blocked ready
    initial begin
        int mode;
        int stretch;
        int rx_cycles;
        bit long_hold_done;
        out_bus.ready  = 1'b0;
        rx_cycles      = 0;
        long_hold_done = 0;
        @(posedge i_rst_n);
        forever begin
            mode    = $urandom_range(0, 3);
            stretch = (mode == 3) ? $urandom_range(2, 20) : $urandom_range(8, 48);
            for (int k = 0; k < stretch; k++) begin
                @(negedge i_clk);
                rx_cycles++;
                if (!long_hold_done && rx_cycles >= 1000 && out_bus.valid) begin
                    out_bus.ready <= 1'b0;
                    repeat (LONG_HOLD) @(negedge i_clk);
                    long_hold_done = 1;
                end
                case (mode)
                    0:       out_bus.ready <= 1'b1;
                    1:       out_bus.ready <= $urandom_range(0, 1);
                    2:       out_bus.ready <= (k % 4 == 0);
                    default: out_bus.ready <= 1'b0;
                endcase
            end
        end
    end

    initial begin
        int boundary_lens [8];
        int sel;
        int len;
        boundary_lens = '{55, 56, 57, 63, 64, 65, 119, 120};
        i_rst_n               = 1'b0;
        in_bus.valid          = 1'b0;
        in_bus.data_byte      = '0;
        in_bus.byte_present   = 1'b0;
        in_bus.end_of_message = 1'b0;
        items_sent            = 0;
        burst_left            = 0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: idle word, empty message, "abc" ending on a byte,
        // extreme bytes with a separate end mark, one-byte message, empty message
        offer_word(8'h5a, 1'b0, 1'b0);
        offer_word(8'hff, 1'b0, 1'b1);
        offer_word(8'h61, 1'b1, 1'b0);
        offer_word(8'h62, 1'b1, 1'b0);
        offer_word(8'h63, 1'b1, 1'b1);
        offer_word(8'h00, 1'b1, 1'b0);
        offer_word(8'hff, 1'b1, 1'b0);
        offer_word(8'h00, 1'b0, 1'b0);
        offer_word(8'h00, 1'b0, 1'b1);
        offer_word(8'h80, 1'b1, 1'b1);
        offer_word(8'h3c, 1'b0, 1'b1);
        wait_drained();

        while (items_sent < 220) begin
            sel = $urandom_range(0, 19);
            if (sel < 14)
                len = $urandom_range(0, 10);
            else if (sel < 19)
                len = boundary_lens[$urandom_range(0, 7)];
            else
                len = $urandom_range(100, 130);
            send_message(len, $urandom_range(0, 1));
            if ($urandom_range(0, 7) == 0)
                wait_drained();
        end

        wait_drained();
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

[files.f]
hw/rtl/sha1_pkg.sv
hw/rtl/sha1_if.sv
hw/rtl/sha1_message_digest.sv
sim/sha1_digest_checker.sv
sim/sha1_message_digest_tb.sv
